[rtl/core/bba_pkg.sv]
// Shared constants, types and helpers for the bitmap block allocator.
`default_nettype none
package bba_pkg;

  localparam int MAX_BLOCKS    = 4096;
  localparam int MAP_WORD_BITS = 64;
  localparam int MAP_WORDS     = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

  localparam int BLK_W  = 13;                          // block number field width
  localparam int STAT_W = 2;
  localparam int BIT_W  = $clog2(MAP_WORD_BITS);
  localparam int WORD_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_A  = (BLK_W > CNT_W) ? BLK_W : CNT_W;
  localparam int CMP_W  = (CMP_A > BIT_W + WORD_W) ? CMP_A : BIT_W + WORD_W;

  localparam int APB_DW = 32;
  localparam int APB_AW = 2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_BAD_ARG  = 2'd2;

  localparam logic [BLK_W-1:0] TOTAL_RESET = BLK_W'(MAX_BLOCKS);

  typedef logic [MAP_WORD_BITS-1:0] map_word_t;

  typedef struct packed {
    logic              rd_en;
    logic [WORD_W-1:0] rd_addr;
    logic              wr_en;
    logic [WORD_W-1:0] wr_addr;
    map_word_t         wr_data;
  } mem_req_t;

  // Index of the lowest set bit; binary halving, one level per index bit.
  function automatic logic [BIT_W-1:0] lowest_set(input map_word_t v);
    map_word_t         cur;
    map_word_t         low_mask;
    logic [BIT_W-1:0]  idx;
    int                half;
    cur = v;
    idx = '0;
    for (int lvl = BIT_W - 1; lvl >= 0; lvl--) begin
      half     = 1 << lvl;
      low_mask = {MAP_WORD_BITS{1'b1}} >> (MAP_WORD_BITS - half);
      if ((cur & low_mask) == '0) begin
        idx[lvl] = 1'b1;
        cur      = cur >> half;
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

[rtl/core/bitmap_block_allocator.sv]
// Top level: block-count register on the APB port, sequencer and bitmap memory.
//
//   channel   handshake            payload
//   request   start / busy         in_action, in_block_number
//   result    out_valid (1 cycle)  out_granted_block, out_status
//   config    psel/penable/pwrite  paddr, pwdata, prdata (total_blocks at 0x0)
//
// Allocate: the transfer reads word 0, then the scan tests 1..64 words,
// one bitmap word per cycle through the memory read port.
// Free: read, then write back. Bad number or zero count: no memory access.
// busy is high while a request is in flight; the next transfer may coincide
// with the result strobe. Results cannot be stalled. Reset is synchronous;
// the bitmap reads as all free after reset with no clearing pass.
`default_nettype none
module bitmap_block_allocator
  import bba_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_action,
  input  wire logic [BLK_W-1:0]   in_block_number,
  output logic                    out_valid,
  output logic [BLK_W-1:0]        out_granted_block,
  output logic [STAT_W-1:0]       out_status,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [APB_AW-1:0]  paddr,
  input  wire logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready
);

  logic [BLK_W-1:0]  cfg_total_blocks_r;
  logic              cfg_wr;
  mem_req_t          mem_req;
  map_word_t         mem_rd_data;

  assign pready = 1'b1;
  // single register; every address decodes to it
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {{(APB_DW - BLK_W){1'b0}}, cfg_total_blocks_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_total_blocks_r <= TOTAL_RESET;
    end else if (cfg_wr) begin
      cfg_total_blocks_r <= pwdata[BLK_W-1:0];
    end
  end

  bba_scan_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_block_number   (in_block_number),
    .total_blocks      (cfg_total_blocks_r),
    .mem_req           (mem_req),
    .mem_rd_data       (mem_rd_data),
    .out_valid         (out_valid),
    .out_granted_block (out_granted_block),
    .out_status        (out_status)
  );

  bba_map_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

`ifndef ASSERT_OFF
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request produced neither busy nor a result");

  a_bad_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action == ACT_FREE && in_block_number == '0)
      |=> (out_valid && out_status == STATUS_BAD_ARG))
    else $error("free of block zero not rejected");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STATUS_OK) |-> (out_granted_block == '0))
    else $error("failed request returned a block number");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK || out_status == STATUS_NO_SPACE ||
                   out_status == STATUS_BAD_ARG))
    else $error("undefined status code on result");
`endif

endmodule
`default_nettype wire

[rtl/core/bba_map_mem.sv]
// Bitmap word memory: one read and one write port, per-word valid bits for reset.
`default_nettype none
module bba_map_mem
  import bba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire mem_req_t  req,
  output map_word_t      rd_data
);

  map_word_t             mem [MAP_WORDS];
  logic [MAP_WORDS-1:0]  valid_r;
  map_word_t             rd_word_r;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_word_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= valid_r[req.rd_addr];
      end
    end
  end

  // never-written words read as all free
  assign rd_data = rd_vld_r ? rd_word_r : '0;

endmodule
`default_nettype wire

[rtl/core/bba_scan_ctrl.sv]
// Request sequencer: word scan for allocate, read-modify-write for free.
`default_nettype none
module bba_scan_ctrl
  import bba_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_action,
  input  wire logic [BLK_W-1:0]  in_block_number,
  input  wire logic [BLK_W-1:0]  total_blocks,
  output mem_req_t               mem_req,
  input  wire map_word_t         mem_rd_data,
  output logic                   out_valid,
  output logic [BLK_W-1:0]       out_granted_block,
  output logic [STAT_W-1:0]      out_status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FREE = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [WORD_W-1:0]  word_r, word_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BLK_W-1:0]   out_block_r, out_block_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;

  logic [CMP_W-1:0]   limit, limit_m1, num_ext, num_m1, rem, granted;
  logic [WORD_W-1:0]  last_word;
  logic               bad_num, full_word, found;
  map_word_t          word_mask, cand;
  logic [BIT_W-1:0]   hit_idx;

  always_comb begin
    limit = (CMP_W'(total_blocks) > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS)
                                                         : CMP_W'(total_blocks);
    limit_m1  = limit - CMP_W'(1);
    last_word = limit_m1[BIT_W +: WORD_W];
    num_ext   = CMP_W'(in_block_number);
    num_m1    = num_ext - CMP_W'(1);
    bad_num   = (num_ext == '0) || (num_ext > limit);

    // bits of the current word that lie below the block count
    rem       = limit - CMP_W'({word_r, {BIT_W{1'b0}}});
    full_word = rem >= CMP_W'(MAP_WORD_BITS);
    word_mask = full_word ? {MAP_WORD_BITS{1'b1}}
                          : ~({MAP_WORD_BITS{1'b1}} << rem[BIT_W-1:0]);
    cand      = ~mem_rd_data & word_mask;
    found     = |cand;
    hit_idx   = lowest_set(cand);
    granted   = CMP_W'({word_r, hit_idx}) + CMP_W'(1);
  end

  always_comb begin
    state_nxt      = state_r;
    word_nxt       = word_r;
    bit_nxt        = bit_r;
    out_valid_nxt  = 1'b0;
    out_block_nxt  = '0;
    out_status_nxt = STATUS_OK;
    mem_req        = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_action == ACT_FREE) begin
            if (bad_num) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STATUS_BAD_ARG;
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = num_m1[BIT_W +: WORD_W];
              word_nxt        = num_m1[BIT_W +: WORD_W];
              bit_nxt         = num_m1[BIT_W-1:0];
              state_nxt       = ST_FREE;
            end
          end else if (limit == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_NO_SPACE;
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = '0;
            word_nxt        = '0;
            state_nxt       = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // prefetch the next word while testing this one
        if (word_r != last_word) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = word_r + WORD_W'(1);
        end
        if (found) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = word_r;
          mem_req.wr_data = mem_rd_data | (map_word_t'(1) << hit_idx);
          out_valid_nxt   = 1'b1;
          out_block_nxt   = granted[BLK_W-1:0];
          state_nxt       = ST_IDLE;
        end else if (word_r == last_word) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_NO_SPACE;
          state_nxt      = ST_IDLE;
        end else begin
          word_nxt = word_r + WORD_W'(1);
        end
      end
      ST_FREE: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = word_r;
        mem_req.wr_data = mem_rd_data & ~(map_word_t'(1) << bit_r);
        out_valid_nxt   = 1'b1;
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r       <= word_nxt;
    bit_r        <= bit_nxt;
    out_block_r  <= out_block_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_granted_block = out_block_r;
  assign out_status        = out_status_r;

endmodule
`default_nettype wire

[sim/tb_bitmap_block_allocator.sv]
// Self-checking testbench for the first-fit bitmap block allocator.
module tb_bitmap_block_allocator;
  import bba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [APB_AW-1:0] REG_TOTAL_BLOCKS = 2'd0;
  localparam int ITEMS_PER_PHASE = 500;
  localparam int NUM_PHASES = 4;
  localparam int SETTLE_CYCLES = 80;   // longest allocate scan plus margin

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

  typedef struct packed {
    logic [BLK_W-1:0]  grant;
    logic [STAT_W-1:0] stat;
  } alloc_result_t;

  typedef struct packed {
    row_kind_t         kind;
    logic              act;
    logic [BLK_W-1:0]  val;     // block number, or new block count for ROW_CFG
    logic              typed;   // expected result given in the row
    logic [BLK_W-1:0]  grant;
    logic [STAT_W-1:0] stat;
  } dir_row_t;

  localparam int NUM_DIR = 25;
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{ROW_REQ, ACT_ALLOC, 13'd0,    1'b1, 13'd1, STATUS_OK},
    '{ROW_REQ, ACT_ALLOC, 13'd0,    1'b1, 13'd2, STATUS_OK},
    '{ROW_REQ, ACT_ALLOC, 13'd0,    1'b1, 13'd3, STATUS_OK},
    '{ROW_REQ, ACT_FREE,  13'd0,    1'b1, 13'd0, STATUS_BAD_ARG},
    '{ROW_REQ, ACT_FREE,  13'd4097, 1'b1, 13'd0, STATUS_BAD_ARG},
    '{ROW_REQ, ACT_FREE,  13'd8191, 1'b1, 13'd0, STATUS_BAD_ARG},
    '{ROW_REQ, ACT_FREE,  13'd2,    1'b1, 13'd0, STATUS_OK},
    '{ROW_REQ, ACT_ALLOC, 13'd0,    1'b1, 13'd2, STATUS_OK},
    // free of a block that is already free
    '{ROW_REQ, ACT_FREE,  13'd4096, 1'b1, 13'd0, STATUS_OK},
    '{ROW_REQ, ACT_ALLOC, 13'd8191, 1'b1, 13'd4, STATUS_OK},
    '{ROW_REQ, ACT_FREE,  13'd1,    1'b1, 13'd0, STATUS_OK},
    '{ROW_REQ, ACT_FREE,  13'd1,    1'b1, 13'd0, STATUS_OK},
    '{ROW_CFG, ACT_ALLOC, 13'd0,    1'b0, 13'd0, STATUS_OK},
    '{ROW_REQ, ACT_ALLOC, 13'd0,    1'b1, 13'd0, STATUS_NO_SPACE},
    '{ROW_REQ, ACT_FREE,  13'd1,    1'b1, 13'd0, STATUS_BAD_ARG},
    // count above capacity clamps to MAX_BLOCKS
    '{ROW_CFG, ACT_ALLOC, 13'd8191, 1'b0, 13'd0, STATUS_OK},
    '{ROW_REQ, ACT_FREE,  13'd4096, 1'b0, 13'd0, STATUS_OK},
    '{ROW_REQ, ACT_FREE,  13'd4097, 1'b1, 13'd0, STATUS_BAD_ARG},
    // shrink below used blocks: 2..4 used, only 1 reachable
    '{ROW_CFG, ACT_ALLOC, 13'd3,    1'b0, 13'd0, STATUS_OK},
    '{ROW_REQ, ACT_ALLOC, 13'd0,    1'b1, 13'd1, STATUS_OK},
    '{ROW_REQ, ACT_ALLOC, 13'd0,    1'b1, 13'd0, STATUS_NO_SPACE},
    '{ROW_REQ, ACT_FREE,  13'd4,    1'b1, 13'd0, STATUS_BAD_ARG},
    '{ROW_CFG, ACT_ALLOC, 13'd4096, 1'b0, 13'd0, STATUS_OK},
    '{ROW_REQ, ACT_FREE,  13'd4,    1'b0, 13'd0, STATUS_OK},
    '{ROW_REQ, ACT_ALLOC, 13'd0,    1'b0, 13'd0, STATUS_OK}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_action = ACT_ALLOC;
  logic [BLK_W-1:0]  in_block_number = '0;
  logic              out_valid;
  logic [BLK_W-1:0]  out_granted_block;
  logic [STAT_W-1:0] out_status;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  bitmap_block_allocator u_dut (
    .clk, .rst_n, .start, .busy, .in_action, .in_block_number,
    .out_valid, .out_granted_block, .out_status,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  bit               blk_used [MAX_BLOCKS];
  logic [BLK_W-1:0] block_count = TOTAL_RESET;
  int               high_water = 0;
  alloc_result_t    pending_results [$];
  int               errors = 0;
  int               idle_pct = 0;

  function automatic int eff_count();
    return (int'(block_count) > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_count);
  endfunction

  function automatic alloc_result_t predict_request(input logic act,
                                                    input logic [BLK_W-1:0] num);
    alloc_result_t r;
    int lim;
    lim = eff_count();
    r.grant = '0;
    if (act == ACT_ALLOC) begin
      r.stat = STATUS_NO_SPACE;
      for (int b = 0; b < lim; b++) begin
        if (!blk_used[b]) begin
          blk_used[b] = 1'b1;
          r.grant = BLK_W'(b + 1);
          r.stat = STATUS_OK;
          if (b + 1 > high_water) high_water = b + 1;
          break;
        end
      end
    end else if (num == '0 || int'(num) > lim) begin
      r.stat = STATUS_BAD_ARG;
    end else begin
      blk_used[int'(num) - 1] = 1'b0;
      r.stat = STATUS_OK;
    end
    return r;
  endfunction

  // mostly blocks near the used region, some out-of-range and raw numbers
  function automatic logic [BLK_W-1:0] pick_free_number();
    int sel;
    sel = $urandom_range(99);
    if (sel < 80) return BLK_W'($urandom_range(high_water + 1, 1));
    else if (sel < 87) return '0;
    else if (sel < 93) return BLK_W'(eff_count() + 1);
    else return BLK_W'($urandom);
  endfunction

  task automatic send_request(input logic act, input logic [BLK_W-1:0] num,
                              input logic typed, input alloc_result_t typed_res);
    alloc_result_t pred;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_block_number <= num;
    do @(posedge clk); while (busy);
    pred = predict_request(act, num);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_block_count(input logic [BLK_W-1:0] count);
    logic [APB_DW-1:0] rd;
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_TOTAL_BLOCKS;
    pwdata <= APB_DW'(count);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    block_count = count;
    // read back through a second transfer
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[BLK_W-1:0] !== count) begin
      $display("%0t: total_blocks readback expected %0d actual %0d",
               $time, count, rd[BLK_W-1:0]);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    alloc_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result expected none actual granted %0d status %0d",
                 $time, out_granted_block, out_status);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_granted_block !== exp_res.grant) begin
          $display("%0t: granted_block expected %0d actual %0d",
                   $time, exp_res.grant, out_granted_block);
          errors++;
        end
        if (out_status !== exp_res.stat) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.stat, out_status);
          errors++;
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int phase_idle [NUM_PHASES];
    int phase_alloc [NUM_PHASES];
    logic [BLK_W-1:0] phase_count [NUM_PHASES];
    alloc_result_t typed_res;
    logic act;

    phase_idle = '{0, 58, 0, 31};
    phase_alloc = '{85, 60, 85, 55};
    phase_count[0] = 13'd4096;
    phase_count[1] = 13'd100;
    phase_count[2] = 13'd8191;
    phase_count[3] = BLK_W'($urandom_range(300, 1));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        write_block_count(DIR_ROWS[i].val);
      end else begin
        typed_res.grant = DIR_ROWS[i].grant;
        typed_res.stat = DIR_ROWS[i].stat;
        send_request(DIR_ROWS[i].act, DIR_ROWS[i].val, DIR_ROWS[i].typed, typed_res);
      end
    end

    typed_res = '0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_block_count(phase_count[p]);
      idle_pct = phase_idle[p];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 1 && n == ITEMS_PER_PHASE / 2) wait_idle();
        act = ($urandom_range(99) < phase_alloc[p]) ? ACT_ALLOC : ACT_FREE;
        send_request(act, (act == ACT_ALLOC) ? BLK_W'($urandom) : pick_free_number(),
                     1'b0, typed_res);
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
